@@ rtl/core/rtdc_pkg.sv @@
// Shared types, widths and fixed-point constants of the RTD temperature converter.
package rtdc_pkg;

  // Field and datapath widths
  localparam int REF_W    = 16;
  localparam int NOM_W    = 14;
  localparam int NUM_W    = 40;  // ratio numerator and quotient (Q24)
  localparam int XQ_FRAC  = 24;
  localparam int ARG_W    = 42;  // square-root argument (Q16)
  localparam int ROOT_W   = 21;
  localparam int SREM_W   = 23;
  localparam int ACC_W    = 35;  // Horner accumulator, Q24 signed
  localparam int X_W      = 24;
  localparam int X_HALF   = 12;
  localparam int C4_W     = 23;
  localparam int DQ_HALF  = 20;
  localparam int TEMP_W   = 17;

  localparam int DIV_CELLS  = NUM_W;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int HORNER_N   = 5;

  // Configuration register indexes
  localparam logic CFG_REF = 1'b0;
  localparam logic CFG_NOM = 1'b1;

  localparam logic [REF_W-1:0] REF_RESET = 16'd3440;
  localparam logic [NOM_W-1:0] NOM_RESET = 14'd800;

  // Quadratic branch constants, scaled by 1/|B|
  localparam longint A_Q8_L = (64'd39083000 * 64'd256 + 64'd2887) / 64'd5775;
  localparam longint C4_L   = (64'd40000000000 + 64'd2887) / 64'd5775;
  localparam logic [ROOT_W-1:0] A_Q8 = ROOT_W'(A_Q8_L);
  localparam logic [C4_W-1:0]   C4   = C4_W'(C4_L);
  localparam logic [ARG_W-1:0]  A2   = ARG_W'(A_Q8_L * A_Q8_L);

  // Polynomial coefficients c_k * 100^k in Q24, rounded to nearest
  localparam longint P5 = ((64'd15243 << 24) + 64'd5000) / 64'd10000;
  localparam longint P4 = ((64'd28183 << 24) + 64'd5000) / 64'd10000;
  localparam longint P3 = ((64'd4826 << 24) + 64'd500) / 64'd1000;
  localparam longint P2 = ((64'd25859 << 24) + 64'd500) / 64'd1000;
  localparam longint P1 = ((64'd22228 << 24) + 64'd50) / 64'd100;
  localparam longint P0 = ((64'd24202 << 24) + 64'd50) / 64'd100;

  localparam logic signed [ACC_W-1:0] HORNER_INIT = ACC_W'(P5);
  localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_N] = '{
    ACC_W'(-P4), ACC_W'(-P3), ACC_W'(P2), ACC_W'(P1), ACC_W'(-P0)
  };

  // Divider cell payload
  typedef struct packed {
    logic [NOM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_t;

  // Square-root cell payload
  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [ARG_W-1:0]  arg;
    logic              clamp;
  } sq_t;

endpackage

@@ rtl/core/rtd_temperature_convert_core.sv @@
// Top level of the RTD temperature converter: ratio divider, quadratic and polynomial paths.
//
//  channel | direction | handshake                  | payload
//  in_     | input     | in_tvalid / in_tready      | tdata: rtd_code
//  out_    | output    | out_tvalid / out_tready    | tdata: temperature; tuser: flags
//  cfg_    | input     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; the pipeline runs through the 40-cell
// division chain, the two quadratic stages and the 21-cell square-root chain that follow it.
// rst_n clears the valid pipeline and the configuration registers to their reset values.
// A stalled output freezes the whole pipeline; in_tready follows the output register.
// cfg_ready is always high.
module rtd_temperature_convert_core #(
  parameter int CODE_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] rtd_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] temperature
  output logic [1:0]  out_tuser,  // [0] used_polynomial, [1] root_clamped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PROD_W  = CODE_BITS + rtdc_pkg::REF_W;
  localparam int PAD_W   = rtdc_pkg::XQ_FRAC - CODE_BITS;
  localparam int QD      = 2 + rtdc_pkg::SQRT_CELLS;
  localparam int PD      = QD - 2 * rtdc_pkg::HORNER_N - 1;
  localparam int VN      = 2 + rtdc_pkg::DIV_CELLS + QD;
  localparam int QP_W    = rtdc_pkg::DQ_HALF + rtdc_pkg::C4_W;
  localparam int TERM_W  = rtdc_pkg::NUM_W + rtdc_pkg::C4_W - 8;
  localparam int TQ_W    = rtdc_pkg::ROOT_W + 1;
  localparam logic [TQ_W-1:0] T_MAX_Q = TQ_W'(65535);

  logic adv;

  // configuration registers
  logic [rtdc_pkg::REF_W-1:0] ref_r;
  logic [rtdc_pkg::NOM_W-1:0] nom_r;
  logic [rtdc_pkg::NOM_W-1:0] nom_eff;

  assign cfg_ready = 1'b1;
  assign nom_eff   = (nom_r == '0) ? rtdc_pkg::NOM_W'(1) : nom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= rtdc_pkg::REF_RESET;
      nom_r <= rtdc_pkg::NOM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtdc_pkg::CFG_REF: ref_r <= cfg_data;
        rtdc_pkg::CFG_NOM: nom_r <= cfg_data[rtdc_pkg::NOM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: move whenever the output register is free or drains
  logic out_valid_r;
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  logic [VN-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[VN-2:0], in_tvalid};
      out_valid_r <= vld_r[VN-1];
    end
  end

  // capture code, then scale by the reference resistance
  logic [15:0]           code_full;
  logic [CODE_BITS-1:0]  code_r;
  logic [PROD_W-1:0]     prod_r;

  assign code_full = {1'b0, in_tdata[14:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= code_full[CODE_BITS-1:0];
      prod_r <= code_r * ref_r;
    end
  end

  // division chain: xq = (code*ref << (24-CODE_BITS)) / nom
  rtdc_pkg::div_t div_in;
  rtdc_pkg::div_t div_q [rtdc_pkg::DIV_CELLS];

  always_comb begin
    div_in.rem = '0;
    div_in.num = {prod_r, {PAD_W{1'b0}}};
    div_in.quo = '0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < rtdc_pkg::DIV_CELLS; gi++) begin : g_div
      if (gi == 0) begin : g_first
        rtdc_div_cell u_cell (
          .clk(clk), .en(adv), .den(nom_eff), .d_i(div_in), .d_o(div_q[gi])
        );
      end else begin : g_next
        rtdc_div_cell u_cell (
          .clk(clk), .en(adv), .den(nom_eff), .d_i(div_q[gi-1]), .d_o(div_q[gi])
        );
      end
    end
  endgenerate

  logic [rtdc_pkg::NUM_W-1:0] xq;
  logic                       xq_poly;
  assign xq      = div_q[rtdc_pkg::DIV_CELLS-1].quo;
  assign xq_poly = ~|xq[rtdc_pkg::NUM_W-1:rtdc_pkg::XQ_FRAC];

  // quadratic path: (xq - 1) * C4 in two partial products
  logic [rtdc_pkg::NUM_W-1:0] dq;
  logic [QP_W-1:0]            qlo_r, qhi_r;
  assign dq = xq - (rtdc_pkg::NUM_W'(1) << rtdc_pkg::XQ_FRAC);

  always_ff @(posedge clk) begin
    if (adv) begin
      qlo_r <= dq[rtdc_pkg::DQ_HALF-1:0] * rtdc_pkg::C4;
      qhi_r <= dq[rtdc_pkg::NUM_W-1:rtdc_pkg::DQ_HALF] * rtdc_pkg::C4;
    end
  end

  // root argument A^2 - term, clamped at zero
  logic [TERM_W+7:0]  qsum;
  logic [TERM_W-1:0]  term;
  logic               clamp;
  rtdc_pkg::sq_t      sq_in, sq_in_r;
  rtdc_pkg::sq_t      sq_q [rtdc_pkg::SQRT_CELLS];

  always_comb begin
    qsum  = {qhi_r, {rtdc_pkg::DQ_HALF{1'b0}}} + (TERM_W + 8)'(qlo_r);
    term  = qsum[TERM_W+7:8];
    clamp = term > TERM_W'(rtdc_pkg::A2);
    sq_in.rem   = '0;
    sq_in.root  = '0;
    sq_in.arg   = clamp ? '0 : rtdc_pkg::A2 - term[rtdc_pkg::ARG_W-1:0];
    sq_in.clamp = clamp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_in_r <= sq_in;
    end
  end

  generate
    for (gi = 0; gi < rtdc_pkg::SQRT_CELLS; gi++) begin : g_sqrt
      if (gi == 0) begin : g_first
        rtdc_sqrt_cell u_cell (.clk(clk), .en(adv), .s_i(sq_in_r), .s_o(sq_q[gi]));
      end else begin : g_next
        rtdc_sqrt_cell u_cell (.clk(clk), .en(adv), .s_i(sq_q[gi-1]), .s_o(sq_q[gi]));
      end
    end
  endgenerate

  // polynomial path: Horner chain on the fractional ratio
  logic signed [rtdc_pkg::ACC_W-1:0] h_acc [rtdc_pkg::HORNER_N];
  logic [rtdc_pkg::X_W-1:0]          h_x   [rtdc_pkg::HORNER_N];

  generate
    for (gi = 0; gi < rtdc_pkg::HORNER_N; gi++) begin : g_horner
      if (gi == 0) begin : g_first
        rtdc_horner_stage #(.COEF(rtdc_pkg::HORNER_COEF[gi])) u_stage (
          .clk(clk), .en(adv), .acc_i(rtdc_pkg::HORNER_INIT),
          .x_i(xq[rtdc_pkg::X_W-1:0]), .acc_o(h_acc[gi]), .x_o(h_x[gi])
        );
      end else begin : g_next
        rtdc_horner_stage #(.COEF(rtdc_pkg::HORNER_COEF[gi])) u_stage (
          .clk(clk), .en(adv), .acc_i(h_acc[gi-1]), .x_i(h_x[gi-1]),
          .acc_o(h_acc[gi]), .x_o(h_x[gi])
        );
      end
    end
  endgenerate

  // round Q24 to Q6, halves away from zero, and saturate
  logic signed [rtdc_pkg::ACC_W-1:0] pacc;
  logic [rtdc_pkg::ACC_W-1:0]        pmag;
  logic [rtdc_pkg::ACC_W-1:0]        prnd;
  logic signed [rtdc_pkg::ACC_W-1:0] pt;
  logic signed [rtdc_pkg::TEMP_W-1:0] pt_nxt, pt_r;
  logic signed [rtdc_pkg::TEMP_W-1:0] pt_dly_r [PD];

  always_comb begin
    pacc = h_acc[rtdc_pkg::HORNER_N-1];
    pmag = pacc[rtdc_pkg::ACC_W-1] ? -pacc : pacc;
    prnd = (pmag + (rtdc_pkg::ACC_W'(1) << 17)) >> 18;
    pt   = pacc[rtdc_pkg::ACC_W-1] ? -$signed(prnd) : $signed(prnd);
    if (pt > rtdc_pkg::ACC_W'(65535)) begin
      pt_nxt = rtdc_pkg::TEMP_W'(65535);
    end else if (pt < -rtdc_pkg::ACC_W'(65536)) begin
      pt_nxt = rtdc_pkg::TEMP_W'(-65536);
    end else begin
      pt_nxt = pt[rtdc_pkg::TEMP_W-1:0];
    end
  end

  // branch flag and polynomial result wait for the root chain
  logic [QD-1:0] poly_dly_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r       <= pt_nxt;
      pt_dly_r[0] <= pt_r;
      for (int i = 1; i < PD; i++) begin
        pt_dly_r[i] <= pt_dly_r[i-1];
      end
      poly_dly_r <= {poly_dly_r[QD-2:0], xq_poly};
    end
  end

  // quadratic result (A - s + 4) >> 3, saturated high
  logic [rtdc_pkg::ROOT_W-1:0] root;
  logic [TQ_W-1:0]             tq_sum;
  logic [TQ_W-1:0]             tq;
  logic [rtdc_pkg::TEMP_W-1:0] qt;

  always_comb begin
    root   = sq_q[rtdc_pkg::SQRT_CELLS-1].root;
    tq_sum = {1'b0, rtdc_pkg::A_Q8} - {1'b0, root} + TQ_W'(4);
    tq     = tq_sum >> 3;
    qt     = (tq > T_MAX_Q) ? rtdc_pkg::TEMP_W'(65535) : tq[rtdc_pkg::TEMP_W-1:0];
  end

  // output register
  logic [rtdc_pkg::TEMP_W-1:0] temp_r;
  logic                        poly_r, clamped_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (poly_dly_r[QD-1]) begin
        temp_r    <= pt_dly_r[PD-1];
        poly_r    <= 1'b1;
        clamped_r <= 1'b0;
      end else begin
        temp_r    <= qt;
        poly_r    <= 1'b0;
        clamped_r <= sq_q[rtdc_pkg::SQRT_CELLS-1].clamp;
      end
    end
  end

  assign out_tdata = {{(24 - rtdc_pkg::TEMP_W){1'b0}}, temp_r};
  assign out_tuser = {clamped_r, poly_r};

endmodule

@@ rtl/core/rtdc_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per pass.
module rtdc_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rtdc_pkg::NOM_W-1:0]  den,
  input  rtdc_pkg::div_t              d_i,
  output rtdc_pkg::div_t              d_o
);

  logic [rtdc_pkg::NOM_W:0] trial;
  logic [rtdc_pkg::NOM_W:0] diff;
  logic                     ge;
  rtdc_pkg::div_t           d_nxt;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    trial = {d_i.rem, d_i.num[rtdc_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
    d_nxt.rem = ge ? diff[rtdc_pkg::NOM_W-1:0] : trial[rtdc_pkg::NOM_W-1:0];
    d_nxt.num = {d_i.num[rtdc_pkg::NUM_W-2:0], 1'b0};
    d_nxt.quo = {d_i.quo[rtdc_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

@@ rtl/core/rtdc_sqrt_cell.sv @@
// One digit-by-digit square-root cell: produces one root bit per pass.
module rtdc_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  rtdc_pkg::sq_t s_i,
  output rtdc_pkg::sq_t s_o
);

  logic [rtdc_pkg::SREM_W-1:0] rem2;
  logic [rtdc_pkg::SREM_W-1:0] trial;
  logic                        ge;
  rtdc_pkg::sq_t               s_nxt;

  // bring down two argument bits, compare against 4*root+1
  always_comb begin
    rem2  = {s_i.rem[rtdc_pkg::SREM_W-3:0], s_i.arg[rtdc_pkg::ARG_W-1 -: 2]};
    trial = {1'b0, s_i.root[rtdc_pkg::ROOT_W-2:0], 2'b01};
    ge    = rem2 >= trial;
    s_nxt.rem   = ge ? rem2 - trial : rem2;
    s_nxt.root  = {s_i.root[rtdc_pkg::ROOT_W-2:0], ge};
    s_nxt.arg   = {s_i.arg[rtdc_pkg::ARG_W-3:0], 2'b00};
    s_nxt.clamp = s_i.clamp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o <= s_nxt;
    end
  end

endmodule

@@ rtl/core/rtdc_horner_stage.sv @@
// One Horner step: acc*x/2^24 truncated toward zero, plus a coefficient (two stages).
module rtdc_horner_stage #(
  parameter logic signed [rtdc_pkg::ACC_W-1:0] COEF = '0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rtdc_pkg::ACC_W-1:0]  acc_i,
  input  logic [rtdc_pkg::X_W-1:0]           x_i,
  output logic signed [rtdc_pkg::ACC_W-1:0]  acc_o,
  output logic [rtdc_pkg::X_W-1:0]           x_o
);

  localparam int MW = rtdc_pkg::ACC_W - 1;
  localparam int PW = MW + rtdc_pkg::X_HALF;
  localparam int SW = MW + rtdc_pkg::X_W;

  logic [rtdc_pkg::ACC_W-1:0] mag;
  logic [PW-1:0]              plo_r, phi_r;
  logic                       neg_r;
  logic [rtdc_pkg::X_W-1:0]   x_r;
  logic [SW-1:0]              sum;
  logic [rtdc_pkg::ACC_W-1:0] pv;
  logic signed [rtdc_pkg::ACC_W-1:0] acc_nxt;

  // magnitude times the two halves of x
  assign mag = acc_i[rtdc_pkg::ACC_W-1] ? -acc_i : acc_i;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= mag[MW-1:0] * x_i[rtdc_pkg::X_HALF-1:0];
      phi_r <= mag[MW-1:0] * x_i[rtdc_pkg::X_W-1:rtdc_pkg::X_HALF];
      neg_r <= acc_i[rtdc_pkg::ACC_W-1];
      x_r   <= x_i;
    end
  end

  // combine partial products, drop the fraction, restore sign, add coefficient
  always_comb begin
    sum = {phi_r, {rtdc_pkg::X_HALF{1'b0}}} + SW'(plo_r);
    pv  = {1'b0, sum[SW-1:rtdc_pkg::XQ_FRAC]};
    if (neg_r) begin
      pv = -pv;
    end
    acc_nxt = $signed(pv) + COEF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_o <= acc_nxt;
      x_o   <= x_r;
    end
  end

endmodule
